// ===== sv/assert_macros.svh =====
// Assertion helpers used by the matrix unit RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies a later consequent; the delay is set by argument n.
`define AST_DELAY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(n) (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent at the next clock edge, reset included.
`define AST_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/e2r_pkg.sv =====
`default_nettype none

package e2r_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ZW = 34;
    localparam int TW = 18;
    localparam int PW = 2 * TW;
    localparam int EW = 56;
    localparam int OW = 16;
    localparam int LAT = CORDIC_STAGES + 5;

    localparam logic signed [ZW-1:0] HALF_PI_Q29 = 34'sd843314857;
    localparam logic signed [ZW-1:0] PI_Q29 = 34'sd1686629713;
    localparam logic signed [ZW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [EW-1:0] OUT_MAX = 56'sd16384;

    typedef logic signed [TW-1:0] t_trig;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [EW-1:0] t_elem;

    function automatic logic signed [ZW-1:0] atan_q29(input int unsigned i);
        logic signed [ZW-1:0] r;
        case (i)
            0: r = 34'sd421657428;
            1: r = 34'sd248918915;
            2: r = 34'sd131521918;
            3: r = 34'sd66762579;
            4: r = 34'sd33510843;
            5: r = 34'sd16771758;
            6: r = 34'sd8387925;
            7: r = 34'sd4194219;
            8: r = 34'sd2097141;
            9: r = 34'sd1048575;
            10: r = 34'sd524288;
            11: r = 34'sd262144;
            12: r = 34'sd131072;
            13: r = 34'sd65536;
            14: r = 34'sd32768;
            15: r = 34'sd16384;
            16: r = 34'sd8192;
            17: r = 34'sd4096;
            18: r = 34'sd2048;
            19: r = 34'sd1024;
            20: r = 34'sd512;
            21: r = 34'sd256;
            22: r = 34'sd128;
            23: r = 34'sd64;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/euler_angles_to_rotation_matrix_unit.sv =====
// o_valid marks the result of each accepted start once it reaches the output registers r_m;
// the valid pipeline r_vld runs in step with the data path.
// Throughput: one item per cycle; busy is low whenever reset is released.
// Stages: angle folding, the CORDIC micro-rotations, sine and cosine rounding, pairwise
// products, element sums, then rounding with saturation. The receiver cannot stall.
// Synchronous active-low reset clears the valid pipeline; items in flight are dropped.
`default_nettype none
`include "assert_macros.svh"

module euler_angles_to_rotation_matrix_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_roll_angle,
    input  wire logic signed [15:0] i_pitch_angle,
    input  wire logic signed [15:0] i_yaw_angle,
    output logic                    o_valid,
    output logic signed [15:0]      o_m00,
    output logic signed [15:0]      o_m01,
    output logic signed [15:0]      o_m02,
    output logic signed [15:0]      o_m10,
    output logic signed [15:0]      o_m11,
    output logic signed [15:0]      o_m12,
    output logic signed [15:0]      o_m20,
    output logic signed [15:0]      o_m21,
    output logic signed [15:0]      o_m22
);

    localparam int LAT = e2r_pkg::LAT;
    localparam int EW = e2r_pkg::EW;
    localparam int OW = e2r_pkg::OW;

    e2r_pkg::t_trig s1, c1, s2, c2, s3, c3;

    e2r_pkg::t_prod r_c1c2, r_c2s1, r_c1c3, r_s1s3, r_c3s1, r_c1s3, r_c2s3, r_c2c3;
    e2r_pkg::t_trig r_s2;
    e2r_pkg::t_elem r_e [0:8];
    e2r_pkg::t_elem v [0:8];
    logic signed [OW-1:0] n_m [0:8];
    logic signed [OW-1:0] r_m [0:8];
    logic r_vld [0:LAT-1];

    assign busy = !i_rst_n;

    e2r_cordic u_roll  (.i_clk(i_clk), .i_angle(i_roll_angle),  .o_sin(s1), .o_cos(c1));
    e2r_cordic u_pitch (.i_clk(i_clk), .i_angle(i_pitch_angle), .o_sin(s2), .o_cos(c2));
    e2r_cordic u_yaw   (.i_clk(i_clk), .i_angle(i_yaw_angle),   .o_sin(s3), .o_cos(c3));

    always_ff @(posedge i_clk) begin
        r_c1c2 <= c1 * c2;
        r_c2s1 <= c2 * s1;
        r_c1c3 <= c1 * c3;
        r_s1s3 <= s1 * s3;
        r_c3s1 <= c3 * s1;
        r_c1s3 <= c1 * s3;
        r_c2s3 <= c2 * s3;
        r_c2c3 <= c2 * c3;
        r_s2 <= s2;
    end

    always_ff @(posedge i_clk) begin
        r_e[0] <= EW'(r_c1c2) <<< 16;
        r_e[1] <= -(EW'(r_c2s1) <<< 16);
        r_e[2] <= EW'(r_s2) <<< 32;
        r_e[3] <= (EW'(r_c3s1) <<< 16) + EW'(r_c1s3) * EW'(r_s2);
        r_e[4] <= (EW'(r_c1c3) <<< 16) - EW'(r_s1s3) * EW'(r_s2);
        r_e[5] <= -(EW'(r_c2s3) <<< 16);
        r_e[6] <= (EW'(r_s1s3) <<< 16) - EW'(r_c1c3) * EW'(r_s2);
        r_e[7] <= EW'(r_c3s1) * EW'(r_s2) + (EW'(r_c1s3) <<< 16);
        r_e[8] <= EW'(r_c2c3) <<< 16;
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            v[k] = (r_e[k] + (56'sd1 <<< 33)) >>> 34;
            if (v[k] > e2r_pkg::OUT_MAX) begin
                v[k] = e2r_pkg::OUT_MAX;
            end else if (v[k] < -e2r_pkg::OUT_MAX) begin
                v[k] = -e2r_pkg::OUT_MAX;
            end
            n_m[k] = v[k][OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r_m[k] <= n_m[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start && !busy;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_m00 = r_m[0];
    assign o_m01 = r_m[1];
    assign o_m02 = r_m[2];
    assign o_m10 = r_m[3];
    assign o_m11 = r_m[4];
    assign o_m12 = r_m[5];
    assign o_m20 = r_m[6];
    assign o_m21 = r_m[7];
    assign o_m22 = r_m[8];

    `AST_DELAY(a_latency, i_clk, i_rst_n, start && !busy, LAT, o_valid)
    `AST_IMPL(a_range_m00, i_clk, i_rst_n, o_valid, o_m00 <= 16'sd16384 && o_m00 >= -16'sd16384)
    `AST_IMPL(a_range_m22, i_clk, i_rst_n, o_valid, o_m22 <= 16'sd16384 && o_m22 >= -16'sd16384)
    `AST_NEXT(a_reset_clears, i_clk, !i_rst_n, !o_valid)

endmodule

`default_nettype wire

// ===== sv/e2r_cordic.sv =====
`default_nettype none

module e2r_cordic (
    input  wire logic                 i_clk,
    input  wire logic signed [15:0]   i_angle,
    output e2r_pkg::t_trig            o_sin,
    output e2r_pkg::t_trig            o_cos
);

    localparam int N = e2r_pkg::CORDIC_STAGES;
    localparam int ZW = e2r_pkg::ZW;
    localparam int TW = e2r_pkg::TW;

    logic signed [ZW-1:0] r_x [0:N];
    logic signed [ZW-1:0] r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    logic                 r_neg [0:N];

    logic signed [ZW-1:0] n_z0;
    logic                 n_neg0;
    logic signed [ZW-1:0] xf;
    logic signed [ZW-1:0] yf;
    logic signed [ZW-1:0] xr;
    logic signed [ZW-1:0] yr;

    always_comb begin
        n_z0 = {{(ZW-32){i_angle[15]}}, i_angle, 16'b0};
        n_neg0 = 1'b0;
        if (n_z0 > e2r_pkg::HALF_PI_Q29) begin
            n_z0 = n_z0 - e2r_pkg::PI_Q29;
            n_neg0 = 1'b1;
        end else if (n_z0 < -e2r_pkg::HALF_PI_Q29) begin
            n_z0 = n_z0 + e2r_pkg::PI_Q29;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= e2r_pkg::GAIN_Q30;
        r_y[0] <= '0;
        r_z[0] <= n_z0;
        r_neg[0] <= n_neg0;
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (r_z[i] >= 0) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - e2r_pkg::atan_q29(i);
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + e2r_pkg::atan_q29(i);
            end
            r_neg[i+1] <= r_neg[i];
        end
    end

    always_comb begin
        xf = r_neg[N] ? -r_x[N] : r_x[N];
        yf = r_neg[N] ? -r_y[N] : r_y[N];
        xr = (xf + 34'sd8192) >>> 14;
        yr = (yf + 34'sd8192) >>> 14;
    end

    always_ff @(posedge i_clk) begin
        o_cos <= xr[TW-1:0];
        o_sin <= yr[TW-1:0];
    end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } t_angles;

    typedef struct {
        logic signed [15:0] m [9];
    } t_matrix;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_roll_angle;
    logic signed [15:0] i_pitch_angle;
    logic signed [15:0] i_yaw_angle;
    logic               o_valid;
    logic signed [15:0] o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;

    t_angles pending_angles[$];
    t_matrix expected_matrices[$];
    int      error_count;
    int      cycle_count;
    int      gap_left;
    bit      stimulus_done;

    euler_angles_to_rotation_matrix_unit DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_roll_angle(i_roll_angle),
        .i_pitch_angle(i_pitch_angle),
        .i_yaw_angle(i_yaw_angle),
        .o_valid(o_valid),
        .o_m00(o_m00),
        .o_m01(o_m01),
        .o_m02(o_m02),
        .o_m10(o_m10),
        .o_m11(o_m11),
        .o_m12(o_m12),
        .o_m20(o_m20),
        .o_m21(o_m21),
        .o_m22(o_m22)
    );

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void cordic_sin_cos(logic signed [15:0] angle, output longint sn,
                                           output longint cs);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        z = longint'(angle) * 65536;
        x = e2r_pkg::GAIN_Q30;
        y = 0;
        flip = 0;
        if (z > e2r_pkg::HALF_PI_Q29) begin
            z -= e2r_pkg::PI_Q29;
            flip = 1;
        end else if (z < -longint'(e2r_pkg::HALF_PI_Q29)) begin
            z += e2r_pkg::PI_Q29;
            flip = 1;
        end
        for (int i = 0; i < e2r_pkg::CORDIC_STAGES && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z -= longint'(e2r_pkg::atan_q29(i));
            end else begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z += longint'(e2r_pkg::atan_q29(i));
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = floor_shr(x + 8192, 14);
        sn = floor_shr(y + 8192, 14);
    endfunction

    function automatic logic signed [15:0] round_clamp_q14(longint q48);
        longint v;
        v = floor_shr(q48 + (longint'(1) <<< 33), 34);
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v[15:0];
    endfunction

    function automatic t_matrix rotation_matrix(t_angles a);
        longint s1, c1, s2, c2, s3, c3;
        longint k;
        t_matrix r;
        k = 65536;
        cordic_sin_cos(a.roll, s1, c1);
        cordic_sin_cos(a.pitch, s2, c2);
        cordic_sin_cos(a.yaw, s3, c3);
        r.m[0] = round_clamp_q14(c1 * c2 * k);
        r.m[1] = round_clamp_q14(-(c2 * s1 * k));
        r.m[2] = round_clamp_q14(s2 * k * k);
        r.m[3] = round_clamp_q14(c3 * s1 * k + c1 * s2 * s3);
        r.m[4] = round_clamp_q14(c1 * c3 * k - s1 * s2 * s3);
        r.m[5] = round_clamp_q14(-(c2 * s3 * k));
        r.m[6] = round_clamp_q14(s1 * s3 * k - c1 * c3 * s2);
        r.m[7] = round_clamp_q14(c3 * s1 * s2 + c1 * s3 * k);
        r.m[8] = round_clamp_q14(c2 * c3 * k);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic logic signed [15:0] random_angle();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 16'($urandom);
        if (pick == 1) return 16'($urandom_range(0, 1) ? 25736 : -25736);
        return 16'($urandom_range(0, 51472) - 25736);
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic queue_angles(int r, int p, int y);
        t_angles a;
        a.roll = 16'(r);
        a.pitch = 16'(p);
        a.yaw = 16'(y);
        pending_angles.insert(pending_angles.size(), a);
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int corner[8];
        t_angles a;
        corner = '{0, 25736, -25736, 12868, -12868, 32767, -32768, 12869};
        for (int i = 0; i < 8; i++) begin
            queue_angles(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
        end
        queue_angles(12868, 0, 0);
        queue_angles(0, 12868, 0);
        queue_angles(0, 0, 12868);
        queue_angles(-12868, -12868, -12868);
        queue_angles(32767, 32767, 32767);
        queue_angles(-32768, -32768, -32768);
        queue_angles(16'h5555, 16'haaaa, 16'h5555);
        queue_angles(16'haaaa, 16'h5555, 16'haaaa);
        for (int i = 0; i < 1000; i++) begin
            a.roll = random_angle();
            a.pitch = random_angle();
            a.yaw = random_angle();
            pending_angles.insert(pending_angles.size(), a);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                expected_matrices.insert(expected_matrices.size(),
                                         rotation_matrix('{i_roll_angle, i_pitch_angle,
                                                           i_yaw_angle}));
            end
            if (!start || !busy) begin
                if (gap_left > 0 || pending_angles.size() == 0) begin
                    start <= 0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                    if (pending_angles.size() == 0 && gap_left == 0) stimulus_done <= 1;
                end else begin
                    t_angles a;
                    a = pending_angles.pop_front();
                    start <= 1;
                    i_roll_angle <= a.roll;
                    i_pitch_angle <= a.pitch;
                    i_yaw_angle <= a.yaw;
                    gap_left <= random_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_matrices.size() == 0) begin
                report_mismatch("result with no expectation waiting");
            end else begin
                t_matrix e;
                logic signed [15:0] got[9];
                e = expected_matrices.pop_front();
                got = '{o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22};
                for (int i = 0; i < 9; i++) begin
                    if (got[i] !== e.m[i]) begin
                        report_mismatch($sformatf("m%0d%0d got %0d expected %0d",
                                                  i / 3, i % 3, got[i], e.m[i]));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        stimulus_done = 0;
        start = 0;
        i_roll_angle = 0;
        i_pitch_angle = 0;
        i_yaw_angle = 0;
        i_rst_n = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        wait (stimulus_done && expected_matrices.size() == 0);
        repeat (e2r_pkg::LAT + 10) @(posedge i_clk);
        if (error_count == 0 && expected_matrices.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/e2r_pkg.sv
sv/e2r_cordic.sv
sv/euler_angles_to_rotation_matrix_unit.sv
verif/tb_top.sv
